/* design/aht_pkg.sv */
// Shared definitions for the actuator heat throttle: codes, field widths,
// register reset values and the saturating add / decay helpers.
// No dependencies.
package aht_pkg;

    // Field widths
    localparam int HEAT_W   = 17;   // unsigned Q1.16, 65536 is full heat
    localparam int SPEED_W  = 16;
    localparam int FACTOR_W = 16;
    localparam int ACT_W    = 8;
    localparam int OP_W     = 2;
    localparam int CLASS_W  = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [HEAT_W-1:0] FULL_HEAT = 17'd65536;

    // Parameter defaults
    localparam int STEPS_PER_REV_DEF = 200;
    localparam int NUM_COILS_DEF     = 3;

    // Event codes
    typedef enum logic [OP_W-1:0] {
        OP_FIRE  = 2'd0,
        OP_STEP  = 2'd1,
        OP_TICK  = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    // Thermal classes
    typedef enum logic [CLASS_W-1:0] {
        CLASS_NORMAL  = 2'd0,
        CLASS_WARNING = 2'd1,
        CLASS_DANGER  = 2'd2
    } thermal_class_t;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_HEAT_PER_FIRE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HEAT_PER_STEP = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DECAY_FACTOR  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WARN_LEVEL    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DANGER_LEVEL  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_NORMAL  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_WARNING = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_DANGER  = 3'd7;

    // Register reset values
    localparam logic [HEAT_W-1:0]   HEAT_PER_FIRE_RST = 17'd6554;
    localparam logic [HEAT_W-1:0]   HEAT_PER_STEP_RST = 17'd66;
    localparam logic [FACTOR_W-1:0] DECAY_FACTOR_RST  = 16'd65209;
    localparam logic [HEAT_W-1:0]   WARN_LEVEL_RST    = 17'd39322;
    localparam logic [HEAT_W-1:0]   DANGER_LEVEL_RST  = 17'd55706;
    localparam logic [SPEED_W-1:0]  SPEED_NORMAL_RST  = 16'd1000;
    localparam logic [SPEED_W-1:0]  SPEED_WARNING_RST = 16'd600;
    localparam logic [SPEED_W-1:0]  SPEED_DANGER_RST  = 16'd300;

    // Add with clamp at full heat
    function automatic logic [HEAT_W-1:0] sat_add(input logic [HEAT_W-1:0] level,
                                                  input logic [HEAT_W-1:0] amount);
        logic [HEAT_W:0] sum;
        sum = {1'b0, level} + {1'b0, amount};
        sat_add = (sum > {1'b0, FULL_HEAT}) ? FULL_HEAT : sum[HEAT_W-1:0];
    endfunction

    // level * factor / 65536, floored
    function automatic logic [HEAT_W-1:0] decay(input logic [HEAT_W-1:0]   level,
                                                input logic [FACTOR_W-1:0] factor);
        logic [HEAT_W+FACTOR_W-1:0] prod;
        prod = (HEAT_W+FACTOR_W)'(level) * (HEAT_W+FACTOR_W)'(factor);
        decay = prod[HEAT_W+FACTOR_W-1:FACTOR_W];
    endfunction

endpackage

/* design/actuator_heat_throttle_core.sv */
// Actuator heat throttle top level: heat state, class selection and rpm scaling.
// Depends on aht_pkg.
//
// Leaky-integrator thermal throttle for NUM_COILS solenoids and one selector
// stepper. Each input transfer (op on s_tuser, solenoid number on s_tdata)
// updates the heat levels and yields exactly one result transfer that reflects
// the state after the event. The block accepts one transfer per clock cycle
// unless back-pressure on m_tready holds it. The input register feeds the
// heat update, decay multipliers, peak search and class compare straight into
// the output register. The rpm for each of the three speed registers depends
// on the configuration alone. It is worked out beside the heat path by a
// reciprocal multiply by 1/STEPS_PER_REV with a one-step remainder fix, and
// the class only picks one of the three. Back-pressure on m_tready holds the
// result, and then the input register, in place. Heat state only advances when
// an item moves from the input register into the output register.
// Configuration writes on cfg_wr_en take effect at once and must only be made
// while no item is in flight.
module actuator_heat_throttle_core
    import aht_pkg::*;
#(
    parameter int STEPS_PER_REV = STEPS_PER_REV_DEF,  // 1 .. 65535
    parameter int NUM_COILS     = NUM_COILS_DEF       // 1 .. 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // Event stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] actuator
    input  logic [OP_W-1:0]       s_tuser,   // [1:0] op

    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [87:0]           m_tdata    // [1:0] thermal_class, [18:2] peak_heat,
                                             // [34:19] selector_speed, [50:35] selector_rpm,
                                             // [67:51] solenoid_heat, [84:68] stepper_heat,
                                             // [87:85] zero
);

    // Reciprocal for the rpm divide: q0 = speed * 60 * floor(2^22/SPR) >> 22
    // lands on the true quotient or one below it.
    localparam int RECIP_SHIFT = 22;
    localparam int NUM_W       = 22;          // speed * 60 fits in 22 bits
    localparam int K_W         = 28;          // 60 * 2^22 fits in 28 bits
    localparam int PROD_W      = SPEED_W + K_W;
    localparam int unsigned RECIP = (32'd1 << RECIP_SHIFT) / STEPS_PER_REV;
    localparam logic [K_W-1:0]     RPM_K  = K_W'(60 * RECIP);
    localparam logic [SPEED_W-1:0] SPR_C  = SPEED_W'(STEPS_PER_REV);
    localparam logic [NUM_W-1:0]   MUL_60 = NUM_W'(60);

    // speed * 60 / STEPS_PER_REV, floored, clamped to 16 bits
    function automatic logic [SPEED_W-1:0] rpm_of(input logic [SPEED_W-1:0] spd);
        logic [PROD_W-1:0]        est_prod;
        logic [NUM_W-1:0]         est;
        logic [NUM_W-1:0]         num;
        logic [NUM_W+SPEED_W-1:0] qd;
        logic [NUM_W-1:0]         rem;
        logic [NUM_W:0]           quot;
        est_prod = PROD_W'(spd) * PROD_W'(RPM_K);
        est      = est_prod[RECIP_SHIFT +: NUM_W];
        num      = NUM_W'(spd) * MUL_60;
        qd       = (NUM_W+SPEED_W)'(est) * (NUM_W+SPEED_W)'(SPR_C);
        rem      = num - qd[NUM_W-1:0];
        quot     = {1'b0, est} + (NUM_W+1)'(rem >= NUM_W'(SPR_C));
        rpm_of   = (quot[NUM_W:SPEED_W] != '0) ? '1 : quot[SPEED_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    logic [HEAT_W-1:0]   heat_per_fire_reg, heat_per_step_reg;
    logic [FACTOR_W-1:0] decay_factor_reg;
    logic [HEAT_W-1:0]   warn_level_reg, danger_level_reg;
    logic [SPEED_W-1:0]  speed_normal_reg, speed_warning_reg, speed_danger_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heat_per_fire_reg <= HEAT_PER_FIRE_RST;
            heat_per_step_reg <= HEAT_PER_STEP_RST;
            decay_factor_reg  <= DECAY_FACTOR_RST;
            warn_level_reg    <= WARN_LEVEL_RST;
            danger_level_reg  <= DANGER_LEVEL_RST;
            speed_normal_reg  <= SPEED_NORMAL_RST;
            speed_warning_reg <= SPEED_WARNING_RST;
            speed_danger_reg  <= SPEED_DANGER_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_HEAT_PER_FIRE: heat_per_fire_reg <= cfg_wdata;
                REG_HEAT_PER_STEP: heat_per_step_reg <= cfg_wdata;
                REG_DECAY_FACTOR:  decay_factor_reg  <= cfg_wdata[FACTOR_W-1:0];
                REG_WARN_LEVEL:    warn_level_reg    <= cfg_wdata;
                REG_DANGER_LEVEL:  danger_level_reg  <= cfg_wdata;
                REG_SPEED_NORMAL:  speed_normal_reg  <= cfg_wdata[SPEED_W-1:0];
                REG_SPEED_WARNING: speed_warning_reg <= cfg_wdata[SPEED_W-1:0];
                REG_SPEED_DANGER:  speed_danger_reg  <= cfg_wdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // rpm per speed register, off the item path
    logic [SPEED_W-1:0] rpm_normal, rpm_warning, rpm_danger;

    assign rpm_normal  = rpm_of(speed_normal_reg);
    assign rpm_warning = rpm_of(speed_warning_reg);
    assign rpm_danger  = rpm_of(speed_danger_reg);

    // ------------------------------------------------------------------
    // Handshake: input reg -> output reg
    logic in_valid_reg, out_valid_reg;
    logic out_load, in_load;

    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_load) begin
                in_valid_reg <= 1'b1;
            end else if (out_load) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input register
    op_t              op_reg;
    logic [ACT_W-1:0] act_reg;

    always_ff @(posedge aclk) begin
        if (in_load) begin
            op_reg  <= op_t'(s_tuser);
            act_reg <= s_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Heat state and its update
    logic [HEAT_W-1:0] coil_heat_reg  [NUM_COILS];
    logic [HEAT_W-1:0] coil_heat_next [NUM_COILS];
    logic [HEAT_W-1:0] motor_heat_reg, motor_heat_next;

    always_comb begin
        for (int i = 0; i < NUM_COILS; i++) begin
            coil_heat_next[i] = coil_heat_reg[i];
            case (op_reg)
                OP_FIRE: begin
                    if (act_reg == ACT_W'(i + 1)) begin
                        coil_heat_next[i] = sat_add(coil_heat_reg[i], heat_per_fire_reg);
                    end
                end
                OP_TICK:  coil_heat_next[i] = decay(coil_heat_reg[i], decay_factor_reg);
                default: ;
            endcase
        end
        case (op_reg)
            OP_STEP: motor_heat_next = sat_add(motor_heat_reg, heat_per_step_reg);
            OP_TICK: motor_heat_next = decay(motor_heat_reg, decay_factor_reg);
            default: motor_heat_next = motor_heat_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COILS; i++) begin
                coil_heat_reg[i] <= '0;
            end
            motor_heat_reg <= '0;
        end else if (out_load) begin
            coil_heat_reg  <= coil_heat_next;
            motor_heat_reg <= motor_heat_next;
        end
    end

    // ------------------------------------------------------------------
    // Peak, class, speed and queried solenoid on the updated levels
    logic [HEAT_W-1:0]  peak;
    logic [HEAT_W-1:0]  sol_heat;
    thermal_class_t     cls;
    logic [SPEED_W-1:0] speed;
    logic [SPEED_W-1:0] rpm;

    always_comb begin
        peak     = motor_heat_next;
        sol_heat = '0;
        for (int i = 0; i < NUM_COILS; i++) begin
            if (coil_heat_next[i] > peak) begin
                peak = coil_heat_next[i];
            end
            if (act_reg == ACT_W'(i + 1)) begin
                sol_heat = coil_heat_next[i];
            end
        end

        // danger wins over warning
        if (peak >= danger_level_reg) begin
            cls   = CLASS_DANGER;
            speed = speed_danger_reg;
            rpm   = rpm_danger;
        end else if (peak >= warn_level_reg) begin
            cls   = CLASS_WARNING;
            speed = speed_warning_reg;
            rpm   = rpm_warning;
        end else begin
            cls   = CLASS_NORMAL;
            speed = speed_normal_reg;
            rpm   = rpm_normal;
        end
    end

    // Output register
    thermal_class_t     cls_out_reg;
    logic [HEAT_W-1:0]  peak_out_reg, sol_out_reg, step_out_reg;
    logic [SPEED_W-1:0] speed_out_reg, rpm_out_reg;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            cls_out_reg   <= cls;
            peak_out_reg  <= peak;
            sol_out_reg   <= sol_heat;
            step_out_reg  <= motor_heat_next;
            speed_out_reg <= speed;
            rpm_out_reg   <= rpm;
        end
    end

    assign m_tdata = {3'b000, step_out_reg, sol_out_reg, rpm_out_reg,
                      speed_out_reg, peak_out_reg, cls_out_reg};

endmodule

/* tb/sv/actuator_heat_throttle_core_test.sv */
// Self-checking testbench for actuator_heat_throttle_core: directed and random
// events with random idling, checked against a local heat/throttle predictor.
// Depends on aht_pkg and actuator_heat_throttle_core.
module actuator_heat_throttle_core_test;
    import aht_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int COILS       = NUM_COILS_DEF;
    localparam int REV_STEPS   = STEPS_PER_REV_DEF;
    localparam int IDLE_PCT    = 28;

    // Expected contents of one result transfer
    typedef struct {
        thermal_class_t     cls;
        logic [HEAT_W-1:0]  peak;
        logic [SPEED_W-1:0] speed;
        logic [SPEED_W-1:0] rpm;
        logic [HEAT_W-1:0]  coil;
        logic [HEAT_W-1:0]  motor;
    } throttle_status_t;

    // One full register set, raw write values (masked by the block)
    typedef struct {
        logic [CFG_DATA_W-1:0] fire;
        logic [CFG_DATA_W-1:0] step;
        logic [CFG_DATA_W-1:0] decay;
        logic [CFG_DATA_W-1:0] warn;
        logic [CFG_DATA_W-1:0] danger;
        logic [CFG_DATA_W-1:0] spd_n;
        logic [CFG_DATA_W-1:0] spd_w;
        logic [CFG_DATA_W-1:0] spd_d;
    } throttle_cfg_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] actuator
    logic [OP_W-1:0]       s_tuser;   // [1:0] op
    logic                  m_tvalid;
    logic                  m_tready;
    logic [87:0]           m_tdata;   // [1:0] class, [18:2] peak, [34:19] speed,
                                      // [50:35] rpm, [67:51] solenoid, [84:68] stepper

    // Predictor state and register shadow
    logic [HEAT_W-1:0]   coil_level [COILS];
    logic [HEAT_W-1:0]   motor_level;
    logic [HEAT_W-1:0]   heat_fire, heat_step, warn_thr, danger_thr;
    logic [FACTOR_W-1:0] decay_mul;
    logic [SPEED_W-1:0]  spd_normal, spd_warning, spd_danger;

    throttle_status_t expected_status [$];
    int unsigned      mismatch_count;
    int unsigned      result_count;
    int unsigned      cycle_count;
    int unsigned      hold_left;
    bit               src_idle_on;
    bit               snk_idle_on;

    actuator_heat_throttle_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Run-length guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: long hold-off when requested, otherwise random stalls
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= !(snk_idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [HEAT_W-1:0] heat_add(input logic [HEAT_W-1:0] level,
                                                   input logic [HEAT_W-1:0] amount);
        int unsigned total;
        total = int'(level) + int'(amount);
        return (total > 65536) ? FULL_HEAT : total[HEAT_W-1:0];
    endfunction

    function automatic logic [HEAT_W-1:0] heat_decay(input logic [HEAT_W-1:0] level);
        longint unsigned prod;
        prod = longint'(level) * longint'(decay_mul);
        return HEAT_W'(prod >> 16);
    endfunction

    // Applies one event to the heat state and returns the status it yields
    function automatic throttle_status_t apply_heat_event(input op_t op,
                                                          input logic [7:0] act);
        throttle_status_t st;
        bit               idx_ok;
        int unsigned      rpm_full;
        idx_ok = (act >= 1) && (act <= COILS);
        case (op)
            OP_FIRE: begin
                if (idx_ok) coil_level[act-1] = heat_add(coil_level[act-1], heat_fire);
            end
            OP_STEP: begin
                motor_level = heat_add(motor_level, heat_step);
            end
            OP_TICK: begin
                for (int i = 0; i < COILS; i++) coil_level[i] = heat_decay(coil_level[i]);
                motor_level = heat_decay(motor_level);
            end
            default: ;
        endcase
        st.peak = motor_level;
        for (int i = 0; i < COILS; i++)
            if (coil_level[i] > st.peak) st.peak = coil_level[i];
        // danger takes priority over warning
        if (st.peak >= danger_thr) begin
            st.cls   = CLASS_DANGER;
            st.speed = spd_danger;
        end else if (st.peak >= warn_thr) begin
            st.cls   = CLASS_WARNING;
            st.speed = spd_warning;
        end else begin
            st.cls   = CLASS_NORMAL;
            st.speed = spd_normal;
        end
        rpm_full = (int'(st.speed) * 60) / REV_STEPS;
        st.rpm   = (rpm_full > 65535) ? 16'hFFFF : rpm_full[SPEED_W-1:0];
        st.coil  = idx_ok ? coil_level[act-1] : '0;
        st.motor = motor_level;
        return st;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("[%0d] result %0d %s: expected %0d, got %0d",
                 cycle_count, result_count, what, want, got);
        mismatch_count++;
    endtask

    task automatic compare_field(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got) report_mismatch(what, want, got);
    endtask

    always @(posedge aclk) begin : result_check
        throttle_status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_status.size() == 0) begin
                report_mismatch("arrived with nothing outstanding", 0, 0);
            end else begin
                want = expected_status.pop_front();
                compare_field("thermal_class",  want.cls,   m_tdata[1:0]);
                compare_field("peak_heat",      want.peak,  m_tdata[18:2]);
                compare_field("selector_speed", want.speed, m_tdata[34:19]);
                compare_field("selector_rpm",   want.rpm,   m_tdata[50:35]);
                compare_field("solenoid_heat",  want.coil,  m_tdata[67:51]);
                compare_field("stepper_heat",   want.motor, m_tdata[84:68]);
            end
            result_count++;
        end
    end

    // ---------------------------------------------------------------- drivers

    // Offers one event from a falling edge and returns at the falling edge
    // after its transfer
    task automatic send_event(input op_t op, input logic [7:0] act);
        while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= act;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_status.push_back(apply_heat_event(op, act));
        @(negedge aclk);
    endtask

    // Mostly valid fires with some bad indexes; steps, ticks and queries mixed in
    task automatic send_random_events(input int n);
        int   pick;
        op_t  op;
        logic [7:0] act;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            act  = 8'($urandom_range(255));
            if (pick < 40) begin
                op = OP_FIRE;
                if ($urandom_range(3) != 0) act = 8'($urandom_range(COILS, 1));
            end else if (pick < 60) begin
                op = OP_STEP;
            end else if (pick < 80) begin
                op = OP_TICK;
            end else begin
                op = OP_QUERY;
                if ($urandom_range(2) != 0) act = 8'($urandom_range(COILS, 1));
            end
            send_event(op, act);
        end
    endtask

    // Stops offering, waits out every result and the pipeline tail
    task automatic drain_and_settle;
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // One register write; leaves the write enable high for a following write
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
        case (addr)
            REG_HEAT_PER_FIRE: heat_fire   = data;
            REG_HEAT_PER_STEP: heat_step   = data;
            REG_DECAY_FACTOR:  decay_mul   = data[FACTOR_W-1:0];
            REG_WARN_LEVEL:    warn_thr    = data;
            REG_DANGER_LEVEL:  danger_thr  = data;
            REG_SPEED_NORMAL:  spd_normal  = data[SPEED_W-1:0];
            REG_SPEED_WARNING: spd_warning = data[SPEED_W-1:0];
            REG_SPEED_DANGER:  spd_danger  = data[SPEED_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input throttle_cfg_t c);
        drain_and_settle();
        write_reg(REG_HEAT_PER_FIRE, c.fire);
        write_reg(REG_HEAT_PER_STEP, c.step);
        write_reg(REG_DECAY_FACTOR,  c.decay);
        write_reg(REG_WARN_LEVEL,    c.warn);
        write_reg(REG_DANGER_LEVEL,  c.danger);
        write_reg(REG_SPEED_NORMAL,  c.spd_n);
        write_reg(REG_SPEED_WARNING, c.spd_w);
        write_reg(REG_SPEED_DANGER,  c.spd_d);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Random settings, mostly in a useful band with the extremes now and then
    function automatic throttle_cfg_t random_settings;
        throttle_cfg_t c;
        case ($urandom_range(7))
            0:       c.fire = 17'd0;
            1:       c.fire = 17'd65536;
            2:       c.fire = 17'($urandom_range(131071));
            default: c.fire = 17'($urandom_range(20000, 300));
        endcase
        case ($urandom_range(7))
            0:       c.step = 17'd0;
            1:       c.step = 17'd65536;
            default: c.step = 17'($urandom_range(6000));
        endcase
        // bit 16 of the decay write is dropped by the block
        case ($urandom_range(7))
            0:       c.decay = {1'($urandom_range(1)), 16'd0};
            1:       c.decay = {1'($urandom_range(1)), 16'hFFFF};
            default: c.decay = {1'($urandom_range(1)), 16'($urandom_range(65535, 52000))};
        endcase
        c.warn = 17'($urandom_range(65536));
        case ($urandom_range(5))
            0:       c.danger = 17'($urandom_range(131071));
            1:       c.danger = 17'($urandom_range(65536));
            default: c.danger = 17'(c.warn + $urandom_range(30000));
        endcase
        c.spd_n = 17'($urandom_range(131071));
        c.spd_w = 17'($urandom_range(131071));
        c.spd_d = 17'($urandom_range(131071));
        return c;
    endfunction

    // ---------------------------------------------------------------- tests

    // Reset settings: first tick on empty state, bad indexes, every op
    task automatic test_default_events;
        send_event(OP_TICK,  8'd0);
        send_event(OP_QUERY, 8'd0);
        send_event(OP_QUERY, 8'd255);
        send_event(OP_FIRE,  8'd0);
        send_event(OP_FIRE,  8'd4);
        send_event(OP_FIRE,  8'd255);
        send_event(OP_FIRE,  8'd1);
        send_event(OP_FIRE,  8'd2);
        send_event(OP_FIRE,  8'd3);
        send_event(OP_STEP,  8'h55);
        send_event(OP_TICK,  8'hAA);
        send_event(OP_QUERY, 8'd2);
    endtask

    // Full-heat adds saturate; equal thresholds put full heat in danger
    task automatic test_saturation_extremes;
        throttle_cfg_t c;
        c = '{fire: 17'd65536, step: 17'd65536, decay: 17'd65535, warn: 17'd65536,
              danger: 17'd65536, spd_n: 17'd0, spd_w: 17'h1FFFF, spd_d: 17'd65535};
        apply_settings(c);
        send_event(OP_FIRE,  8'd1);
        send_event(OP_FIRE,  8'd1);
        send_event(OP_STEP,  8'd0);
        send_event(OP_STEP,  8'd0);
        send_event(OP_QUERY, 8'd3);
        send_event(OP_TICK,  8'd1);
        send_event(OP_QUERY, 8'd1);
    endtask

    // Zero warning level, unreachable danger level, zero decay clears all
    task automatic test_flat_thresholds;
        throttle_cfg_t c;
        c = '{fire: 17'h1FFFF, step: 17'd0, decay: 17'h10000, warn: 17'd0,
              danger: 17'h1FFFF, spd_n: 17'd65535, spd_w: 17'd1, spd_d: 17'd2};
        apply_settings(c);
        send_event(OP_FIRE,  8'd3);
        send_event(OP_STEP,  8'd3);
        send_event(OP_TICK,  8'd3);
        send_event(OP_QUERY, 8'd3);
    endtask

    task automatic test_random_settings;
        for (int p = 0; p < 5; p++) begin
            apply_settings(random_settings());
            send_random_events(250);
        end
    endtask

    // Both sides ready throughout: back-to-back transfers
    task automatic test_no_idle_stretch;
        apply_settings(random_settings());
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        send_random_events(300);
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_hold;
        drain_and_settle();
        @(posedge aclk);
        hold_left = 80;
        @(negedge aclk);
        src_idle_on = 1'b0;
        send_random_events(60);
        src_idle_on = 1'b1;
        send_random_events(100);
    endtask

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = REG_HEAT_PER_FIRE;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_QUERY;
        m_tready       = 1'b0;
        mismatch_count = 0;
        result_count   = 0;
        cycle_count    = 0;
        hold_left      = 0;
        src_idle_on    = 1'b1;
        snk_idle_on    = 1'b1;
        for (int i = 0; i < COILS; i++) coil_level[i] = '0;
        motor_level = '0;
        heat_fire   = HEAT_PER_FIRE_RST;
        heat_step   = HEAT_PER_STEP_RST;
        decay_mul   = DECAY_FACTOR_RST;
        warn_thr    = WARN_LEVEL_RST;
        danger_thr  = DANGER_LEVEL_RST;
        spd_normal  = SPEED_NORMAL_RST;
        spd_warning = SPEED_WARNING_RST;
        spd_danger  = SPEED_DANGER_RST;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_default_events();
        test_saturation_extremes();
        test_flat_thresholds();
        test_random_settings();
        test_no_idle_stretch();
        test_output_hold();

        s_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* actuator_heat_throttle_core.f */
design/aht_pkg.sv
design/actuator_heat_throttle_core.sv
tb/sv/actuator_heat_throttle_core_test.sv
